[design/lttb_pkg.sv]
// shared constants for the lttb downsampler
// no dependencies; used by lttb_downsampler, lttb_store and the testbench
`timescale 1ns / 1ps

package lttb_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int MAX_BUCKETS_DEF = 64;
    localparam int COORD_W         = 32;
    localparam int BUCKET_W        = 7;
    // multiplier operand width: a 33-bit coordinate difference plus sign margin
    localparam int MUL_BW          = 34;

endpackage

[design/lttb_downsampler.sv]
// lttb downsampler top level: point loading, in-place insertion sort by x and
// bucket selection under one sequencer; uses lttb_pkg, lttb_store, lttb_mul
// operation: points load one per cycle; the closing transfer starts an insertion sort
// by x, then per candidate point two multiplies on the shared multiplier, two more
// per bucket, plus bucket bound steps and an accumulate step per summed point;
// s_tready is low meanwhile
// reset: asynchronous active low, clears point count, overflow, bucket_count, outputs
`timescale 1ns / 1ps

module lttb_downsampler #(
    parameter int STORE_DEPTH = lttb_pkg::STORE_DEPTH_DEF,
    parameter int MAX_BUCKETS = lttb_pkg::MAX_BUCKETS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,   // point_x, point_y
    input  logic [0:0]                   s_tuser,   // point_valid
    input  logic                         s_tlast,   // set_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [63:0]                  m_tdata,   // out_x, out_y
    output logic [1:0]                   m_tuser,   // out_valid, overflowed
    output logic                         m_tlast,   // out_last
    input  logic                         cfg_we,
    input  logic [lttb_pkg::BUCKET_W-1:0] cfg_wdata  // bucket_count
);

    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int ADW = $clog2(STORE_DEPTH);
    localparam int SW  = CW + 34;
    localparam int BW  = lttb_pkg::MUL_BW;
    localparam int PW  = SW + BW;
    localparam int NBW = lttb_pkg::BUCKET_W;
    localparam int XW  = lttb_pkg::COORD_W;

    typedef enum logic [4:0] {
        ST_LOAD, ST_SORT, ST_KEY, ST_INS_RD, ST_INS_CMP, ST_PLAN, ST_ALL,
        ST_LASTPT, ST_EMIT_RD, ST_EMIT_WAIT, ST_MARK, ST_B_INIT, ST_RED,
        ST_SUM_RD, ST_SUM_ACC, ST_BX, ST_BX_W, ST_BY_W, ST_C_RD, ST_C_GET,
        ST_C_M1, ST_C_M2, ST_B_NEXT, ST_DONE
    } state_t;

    state_t state_reg, ret_reg;

    logic [CW-1:0]  cnt_reg;
    logic           ovf_reg;
    logic [NBW-1:0] bc_reg, nb_reg, d_reg, bi_reg;
    logic [CW-1:0]  i_reg, j_reg, pos_reg, emit_pos_reg;
    logic           emit_last_reg;
    logic [2*XW-1:0] key_reg;
    logic [CW+1:0]  q_reg;
    logic [CW:0]    r_reg;
    logic           first_reg;
    logic [CW-1:0]  start_reg, center_reg, end_reg, csum_reg, best_reg;
    logic signed [SW-1:0] sx_reg, sy_reg, bx_reg, by_reg;
    logic signed [XW-1:0] px_reg, py_reg;
    logic signed [BW-1:0] dy_reg;
    logic signed [PW-1:0] p1_reg;
    logic [PW:0]    best_area_reg;

    logic           m_tvalid_reg, out_last_reg;
    logic [63:0]    out_data_reg;
    logic [1:0]     out_user_reg;

    // store and multiplier hookup
    logic            wr_en;
    logic [ADW-1:0]  wr_addr, rd_addr;
    logic [2*XW-1:0] wr_data, rd_data;
    logic            mul_start, mul_busy, mul_done;
    logic signed [SW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    logic           in_xfer, out_free, out_load;
    logic [CW-1:0]  nm2;
    logic [NBW-1:0] nb_sat;
    logic [CW+2:0]  e_val;
    logic signed [PW:0] diff;
    logic [PW:0]    area;
    logic signed [XW-1:0] rd_x, rd_y;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign nm2      = cnt_reg - CW'(2);
    assign nb_sat   = (bc_reg > NBW'(MAX_BUCKETS)) ? NBW'(MAX_BUCKETS) : bc_reg;
    assign e_val    = (CW+3)'(q_reg) + (CW+3)'(1);
    assign rd_x     = $signed(rd_data[XW-1:0]);
    assign rd_y     = $signed(rd_data[2*XW-1:XW]);
    assign diff     = $signed({p1_reg[PW-1], p1_reg}) - $signed({mul_p[PW-1], mul_p});
    assign area     = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);
    assign out_load = (state_reg == ST_EMIT_WAIT || state_reg == ST_MARK) && out_free;

    lttb_store #(.DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    lttb_mul #(.AW(SW), .BW(BW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        s_tready  = (state_reg == ST_LOAD);
        wr_en     = 1'b0;
        wr_addr   = cnt_reg[ADW-1:0];
        wr_data   = s_tdata;
        rd_addr   = j_reg[ADW-1:0];
        mul_start = 1'b0;
        mul_a     = by_reg;
        mul_b     = BW'(signed'(rd_x)) - BW'(signed'(px_reg));
        unique case (state_reg)
            ST_LOAD:
            begin
                wr_en = in_xfer && s_tuser[0] && (cnt_reg < CW'(STORE_DEPTH));
            end
            ST_SORT:
            begin
                rd_addr = i_reg[ADW-1:0];
            end
            ST_INS_RD:
            begin
                rd_addr = ADW'(j_reg - CW'(1));
                if (j_reg == '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = key_reg;
                end
            end
            ST_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[ADW-1:0];
                wr_data = (rd_x > $signed(key_reg[XW-1:0])) ? rd_data : key_reg;
            end
            ST_EMIT_RD, ST_EMIT_WAIT:
            begin
                rd_addr = emit_pos_reg[ADW-1:0];
            end
            ST_BX:
            begin
                mul_start = 1'b1;
                mul_a     = SW'(csum_reg);
                mul_b     = BW'(px_reg);
            end
            ST_BX_W:
            begin
                mul_start = mul_done;
                mul_a     = SW'(csum_reg);
                mul_b     = BW'(py_reg);
            end
            ST_C_GET:
            begin
                mul_start = 1'b1;
            end
            ST_C_M1:
            begin
                mul_start = mul_done;
                mul_a     = bx_reg;
                mul_b     = dy_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            ret_reg       <= ST_DONE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            bc_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bc_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_xfer)
                    begin
                        if (s_tuser[0])
                        begin
                            if (cnt_reg < CW'(STORE_DEPTH))
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        if (s_tlast)
                        begin
                            nb_reg    <= nb_sat;
                            i_reg     <= CW'(1);
                            state_reg <= ST_SORT;
                        end
                    end
                end
                ST_SORT:
                begin
                    state_reg <= (i_reg >= cnt_reg) ? ST_PLAN : ST_KEY;
                end
                ST_KEY:
                begin
                    key_reg   <= rd_data;
                    j_reg     <= i_reg;
                    state_reg <= ST_INS_RD;
                end
                ST_INS_RD:
                begin
                    if (j_reg == '0)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_SORT;
                    end
                    else
                    begin
                        state_reg <= ST_INS_CMP;
                    end
                end
                ST_INS_CMP:
                begin
                    // shift the larger entry up, or drop the key in place
                    if (rd_x > $signed(key_reg[XW-1:0]))
                    begin
                        j_reg     <= j_reg - CW'(1);
                        state_reg <= ST_INS_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_SORT;
                    end
                end
                ST_PLAN:
                begin
                    d_reg         <= nb_reg - NBW'(2);
                    emit_pos_reg  <= '0;
                    emit_last_reg <= 1'b0;
                    pos_reg       <= '0;
                    if (cnt_reg <= CW'(nb_reg))
                    begin
                        state_reg <= (cnt_reg == '0) ? ST_MARK : ST_ALL;
                    end
                    else if (nb_reg == NBW'(0))
                    begin
                        state_reg <= ST_MARK;
                    end
                    else if (nb_reg == NBW'(1))
                    begin
                        emit_last_reg <= 1'b1;
                        ret_reg       <= ST_DONE;
                        state_reg     <= ST_EMIT_RD;
                    end
                    else if (nb_reg == NBW'(2))
                    begin
                        ret_reg   <= ST_LASTPT;
                        state_reg <= ST_EMIT_RD;
                    end
                    else
                    begin
                        ret_reg   <= ST_B_INIT;
                        state_reg <= ST_EMIT_RD;
                    end
                end
                ST_ALL:
                begin
                    emit_pos_reg  <= pos_reg;
                    emit_last_reg <= (pos_reg == cnt_reg - CW'(1));
                    ret_reg       <= (pos_reg == cnt_reg - CW'(1)) ? ST_DONE : ST_ALL;
                    pos_reg       <= pos_reg + CW'(1);
                    state_reg     <= ST_EMIT_RD;
                end
                ST_LASTPT:
                begin
                    emit_pos_reg  <= cnt_reg - CW'(1);
                    emit_last_reg <= 1'b1;
                    ret_reg       <= ST_DONE;
                    state_reg     <= ST_EMIT_RD;
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_WAIT;
                end
                ST_EMIT_WAIT:
                begin
                    if (out_free)
                    begin
                        out_data_reg <= rd_data;
                        out_user_reg <= {ovf_reg, 1'b1};
                        out_last_reg <= emit_last_reg;
                        px_reg       <= rd_x;
                        py_reg       <= rd_y;
                        state_reg    <= ret_reg;
                    end
                end
                ST_MARK:
                begin
                    if (out_free)
                    begin
                        out_data_reg <= '0;
                        out_user_reg <= {ovf_reg, 1'b0};
                        out_last_reg <= 1'b1;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_B_INIT:
                begin
                    q_reg     <= '0;
                    r_reg     <= (CW+1)'(nm2);
                    first_reg <= 1'b1;
                    state_reg <= ST_RED;
                end
                ST_RED:
                begin
                    // running quotient of (n-2)*k / (b-2), one subtract per cycle
                    if (r_reg >= (CW+1)'(d_reg))
                    begin
                        r_reg <= r_reg - (CW+1)'(d_reg);
                        q_reg <= q_reg + (CW+2)'(1);
                    end
                    else if (first_reg)
                    begin
                        center_reg <= CW'(e_val);
                        start_reg  <= CW'(1);
                        bi_reg     <= '0;
                        first_reg  <= 1'b0;
                        r_reg      <= r_reg + (CW+1)'(nm2);
                    end
                    else
                    begin
                        end_reg   <= (e_val > (CW+3)'(cnt_reg)) ? cnt_reg : CW'(e_val);
                        j_reg     <= center_reg;
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        csum_reg  <= '0;
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_SUM_RD:
                begin
                    state_reg <= (j_reg < end_reg) ? ST_SUM_ACC : ST_BX;
                end
                ST_SUM_ACC:
                begin
                    sx_reg    <= sx_reg + SW'(rd_x);
                    sy_reg    <= sy_reg + SW'(rd_y);
                    csum_reg  <= csum_reg + CW'(1);
                    j_reg     <= j_reg + CW'(1);
                    state_reg <= ST_SUM_RD;
                end
                ST_BX:
                begin
                    state_reg <= ST_BX_W;
                end
                ST_BX_W:
                begin
                    if (mul_done)
                    begin
                        bx_reg    <= sx_reg - SW'(mul_p);
                        state_reg <= ST_BY_W;
                    end
                end
                ST_BY_W:
                begin
                    if (mul_done)
                    begin
                        by_reg        <= sy_reg - SW'(mul_p);
                        j_reg         <= start_reg;
                        best_reg      <= start_reg;
                        best_area_reg <= '0;
                        state_reg     <= ST_C_RD;
                    end
                end
                ST_C_RD:
                begin
                    if (j_reg < center_reg)
                    begin
                        state_reg <= ST_C_GET;
                    end
                    else
                    begin
                        emit_pos_reg  <= best_reg;
                        emit_last_reg <= 1'b0;
                        ret_reg       <= ST_B_NEXT;
                        state_reg     <= ST_EMIT_RD;
                    end
                end
                ST_C_GET:
                begin
                    dy_reg    <= BW'(signed'(rd_y)) - BW'(signed'(py_reg));
                    state_reg <= ST_C_M1;
                end
                ST_C_M1:
                begin
                    if (mul_done)
                    begin
                        p1_reg    <= mul_p;
                        state_reg <= ST_C_M2;
                    end
                end
                ST_C_M2:
                begin
                    if (mul_done)
                    begin
                        // strictly larger area wins, so the first maximum stays
                        if (area > best_area_reg)
                        begin
                            best_area_reg <= area;
                            best_reg      <= j_reg;
                        end
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= ST_C_RD;
                    end
                end
                ST_B_NEXT:
                begin
                    start_reg  <= center_reg;
                    center_reg <= end_reg;
                    bi_reg     <= bi_reg + NBW'(1);
                    if (bi_reg + NBW'(1) == d_reg)
                    begin
                        state_reg <= ST_LASTPT;
                    end
                    else
                    begin
                        r_reg     <= r_reg + (CW+1)'(nm2);
                        state_reg <= ST_RED;
                    end
                end
                ST_DONE:
                begin
                    cnt_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    state_reg <= ST_LOAD;
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // point count never runs past the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STORE_DEPTH))
        else $error("point count beyond store depth");

    // the multiplier is only started when idle
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    // a result is only loaded into a free output slot
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output overwritten before transfer");

    // no input is taken while the sequencer works
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !s_tready)
        else $error("input ready during computation");

endmodule

[design/lttb_store.sv]
// point store: one write port, one read port with registered read data
// depends on lttb_pkg for the coordinate width
`timescale 1ns / 1ps

module lttb_store #(
    parameter int DEPTH = lttb_pkg::STORE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [2*lttb_pkg::COORD_W-1:0]   wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [2*lttb_pkg::COORD_W-1:0]   rdata
);

    logic [2*lttb_pkg::COORD_W-1:0] mem [DEPTH];
    logic [2*lttb_pkg::COORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/lttb_mul.sv]
// shared sequential signed multiplier, one shift-add step per cycle
// depends on nothing but its parameters
`timescale 1ns / 1ps

module lttb_mul #(
    parameter int AW = 45,
    parameter int BW = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic                 busy,
    output logic                 done,
    output logic signed [AW+BW-1:0] p
);

    localparam int CNTW = $clog2(BW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            neg_reg;
    logic [AW-1:0]   mcand_reg;
    logic [AW:0]     hi_reg;
    logic [BW-1:0]   lo_reg;
    logic [AW:0]     sum;
    logic [AW+BW-1:0] mag;

    assign sum = hi_reg + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= CNTW'(BW);
                neg_reg   <= a[AW-1] ^ b[BW-1];
                mcand_reg <= a[AW-1] ? AW'(-a) : AW'(a);
                lo_reg    <= b[BW-1] ? BW'(-b) : BW'(b);
                hi_reg    <= '0;
            end
            else if (busy_reg)
            begin
                hi_reg  <= {1'b0, sum[AW:1]};
                lo_reg  <= {sum[0], lo_reg[BW-1:1]};
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign mag  = {hi_reg[AW-1:0], lo_reg};
    assign p    = neg_reg ? $signed(-mag) : $signed(mag);
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

[tb/sv/lttb_downsampler_tb.sv]
// self-checking testbench for lttb_downsampler: directed table, then random point sets
// depends on lttb_pkg and the lttb_downsampler rtl; the selection is predicted in-bench
`timescale 1ns / 1ps

module lttb_downsampler_tb;

    localparam int DEPTH     = lttb_pkg::STORE_DEPTH_DEF;
    localparam int NB_MAX    = lttb_pkg::MAX_BUCKETS_DEF;
    localparam int BCW       = lttb_pkg::BUCKET_W;
    localparam int LIMIT     = 4000000;
    localparam int SETTLE    = 40;
    localparam int HOLD_LEN  = 3000;
    localparam int RAND_ITEMS = 170;
    localparam logic signed [31:0] XMIN = 32'sh8000_0000;
    localparam logic signed [31:0] XMAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 valid;
        bit                 last;
        bit                 ovf;
    } sel_pt_t;

    typedef struct {
        int                 bc;     // bucket_count written before the row, -1 keeps it
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 pv;
        bit                 close;
        bit                 typed;  // row carries a typed result
        sel_pt_t            res;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [63:0]         s_tdata;
    logic [0:0]          s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [63:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_we;
    logic [BCW-1:0]      cfg_wdata;

    lttb_downsampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic signed [31:0] pts_x[$];
    logic signed [31:0] pts_y[$];
    bit                 set_ovf;
    int                 buckets;
    sel_pt_t            selected_q[$];

    int  errors;
    int  cycles;
    int  s_idle;
    int  r_stall;
    int  hold_left;
    bit  hold_go;
    bit  hold_seen;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("lttb_downsampler_tb: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= r_stall);
    end

    function automatic sel_pt_t pick(int idx, int order[$]);
        sel_pt_t p;
        p.x     = pts_x[order[idx]];
        p.y     = pts_y[order[idx]];
        p.valid = 1'b1;
        p.last  = 1'b0;
        p.ovf   = set_ovf;
        return p;
    endfunction

    function automatic bit same_pt(sel_pt_t a, sel_pt_t b);
        return a.x === b.x && a.y === b.y && a.valid == b.valid &&
               a.last == b.last && a.ovf == b.ovf;
    endfunction

    // lttb selection over the collected set; appends to selected_q
    task automatic select_points();
        int order[$];
        int n, nb, d, start, center, stop, best, key, j, k;
        longint e, sx, sy, cnt, px, py;
        logic signed [127:0] bx, by, dx, dy, area, best_area;
        sel_pt_t marker;
        int first_new;
        n = pts_x.size();
        nb = (buckets > NB_MAX) ? NB_MAX : buckets;
        first_new = selected_q.size();
        for (int i = 0; i < n; i++)
            order.insert(order.size(), i);
        // stable insertion sort by x
        for (int i = 1; i < n; i++)
        begin
            key = order[i];
            j = i;
            while (j > 0 && pts_x[order[j-1]] > pts_x[key])
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        if (n <= nb)
        begin
            for (int i = 0; i < n; i++)
                selected_q.insert(selected_q.size(), pick(i, order));
        end
        else if (nb == 1)
            selected_q.insert(selected_q.size(), pick(0, order));
        else if (nb == 2)
        begin
            selected_q.insert(selected_q.size(), pick(0, order));
            selected_q.insert(selected_q.size(), pick(n - 1, order));
        end
        else if (nb > 2)
        begin
            d = nb - 2;
            start = 1;
            center = 1 + (n - 2) / d;
            selected_q.insert(selected_q.size(), pick(0, order));
            px = pts_x[order[0]];
            py = pts_y[order[0]];
            for (int i = 0; i < d; i++)
            begin
                e = 1 + (longint'(n - 2) * (i + 2)) / d;
                stop = (e > n) ? n : int'(e);
                sx = 0;
                sy = 0;
                cnt = 0;
                best = start;
                best_area = 0;
                for (k = center; k < stop; k++)
                begin
                    sx += pts_x[order[k]];
                    sy += pts_y[order[k]];
                    cnt++;
                end
                bx = sx - cnt * px;
                by = sy - cnt * py;
                for (k = start; k < center; k++)
                begin
                    dx = longint'(pts_x[order[k]]) - px;
                    dy = longint'(pts_y[order[k]]) - py;
                    area = dx * by - bx * dy;
                    if (area < 0)
                        area = -area;
                    if (area > best_area)
                    begin
                        best_area = area;
                        best = k;
                    end
                end
                selected_q.insert(selected_q.size(), pick(best, order));
                px = pts_x[order[best]];
                py = pts_y[order[best]];
                start = center;
                center = stop;
            end
            selected_q.insert(selected_q.size(), pick(n - 1, order));
        end
        if (selected_q.size() == first_new)
        begin
            marker.x = 0;
            marker.y = 0;
            marker.valid = 1'b0;
            marker.last = 1'b1;
            marker.ovf = set_ovf;
            selected_q.insert(selected_q.size(), marker);
        end
        else
            selected_q[$].last = 1'b1;
        pts_x.delete();
        pts_y.delete();
        set_ovf = 1'b0;
    endtask

    // both sides sampled mid-cycle; the transfer happens at the following rising edge
    always @(negedge clk)
    begin
        sel_pt_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            if (s_tuser[0])
            begin
                if (pts_x.size() < DEPTH)
                begin
                    pts_x.insert(pts_x.size(), s_tdata[31:0]);
                    pts_y.insert(pts_y.size(), s_tdata[63:32]);
                end
                else
                    set_ovf = 1'b1;
            end
            if (s_tlast)
                select_points();
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (selected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: x=%0d y=%0d valid=%0b",
                         $time, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tuser[0]);
                errors++;
            end
            else
            begin
                want = selected_q.pop_front();
                if (m_tdata[31:0] !== want.x || m_tdata[63:32] !== want.y ||
                    m_tuser[0] !== want.valid || m_tuser[1] !== want.ovf ||
                    m_tlast !== want.last)
                begin
                    $display("%0t: mismatch: expected x=%0d y=%0d valid=%0b ovf=%0b last=%0b",
                             $time, want.x, want.y, want.valid, want.ovf, want.last);
                    $display("%0t:           actual x=%0d y=%0d valid=%0b ovf=%0b last=%0b",
                             $time, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
                             m_tuser[0], m_tuser[1], m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic send(logic signed [31:0] x, logic signed [31:0] y, bit pv, bit close);
        bit rdy;
        while ($urandom_range(99) < s_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= pv;
        s_tlast  <= close;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
    endtask

    // sender pauses until every expected result has come and the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (selected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_buckets(int bc);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= bc[BCW-1:0];
        buckets    = bc;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(8)) - 4;
            default:
                case ($urandom_range(3))
                    0: return XMIN;
                    1: return XMAX;
                    2: return 0;
                    default: return -1;
                endcase
        endcase
    endfunction

    // new_bc low keeps the bucket count, so sets follow without a pause
    task automatic rand_set(inout int sent, input bit new_bc);
        int n, mode, bc;
        if (new_bc)
        begin
            if ($urandom_range(7) == 0)
                case ($urandom_range(5))
                    0: bc = 0;
                    1: bc = 1;
                    2: bc = 2;
                    3: bc = NB_MAX;
                    4: bc = NB_MAX + 1;
                    default: bc = 127;
                endcase
            else
                bc = $urandom_range(10, 3);
            set_buckets(bc);
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10);
        mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(1) ? 1 : 2);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(15) == 0)
                send($urandom, $urandom, 1'b0, 1'b0);   // noise item, no point
            send(rand_coord(mode), rand_coord(mode), 1'b1, 1'b0);
            sent++;
        end
        send(rand_coord(mode), rand_coord(mode), 1'($urandom_range(1)), 1'b1);
        sent++;
    endtask

    row_t rows[$];

    function automatic row_t mk(int bc, logic signed [31:0] x, logic signed [31:0] y,
                                bit pv, bit close);
        row_t r;
        r.bc = bc;
        r.x = x;
        r.y = y;
        r.pv = pv;
        r.close = close;
        r.typed = 1'b0;
        r.res = '{0, 0, 0, 0, 0};
        return r;
    endfunction

    initial
    begin
        row_t r;
        int sent;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        errors    = 0;
        cycles    = 0;
        s_idle    = 0;
        r_stall   = 0;
        hold_go   = 1'b0;
        set_ovf   = 1'b0;
        buckets   = 0;

        // zero buckets after reset: point and close together give the empty marker
        r = mk(-1, 5, 7, 1, 1);
        r.typed = 1'b1;
        r.res = '{0, 0, 0, 1, 0};
        rows.insert(rows.size(), r);
        // close with no point
        r = mk(0, 0, 0, 0, 1);
        r.typed = 1'b1;
        r.res = '{0, 0, 0, 1, 0};
        rows.insert(rows.size(), r);
        // one bucket: first point in x order
        rows.insert(rows.size(), mk(1, XMAX, XMIN, 1, 0));
        r = mk(-1, XMIN, XMAX, 1, 0);
        rows.insert(rows.size(), r);
        r = mk(-1, 0, 0, 0, 1);
        r.typed = 1'b1;
        r.res = '{XMIN, XMAX, 1, 1, 0};
        rows.insert(rows.size(), r);
        // two buckets: first and last
        rows.insert(rows.size(), mk(2, 3, 30, 1, 0));
        rows.insert(rows.size(), mk(-1, 1, 10, 1, 0));
        rows.insert(rows.size(), mk(-1, 2, 20, 1, 1));
        // saturated bucket count, ties in x keep arrival order
        rows.insert(rows.size(), mk(127, 4, 1, 1, 0));
        rows.insert(rows.size(), mk(-1, 4, 2, 1, 0));
        rows.insert(rows.size(), mk(-1, -4, 3, 1, 0));
        rows.insert(rows.size(), mk(-1, 4, 3, 1, 1));
        // three buckets over extreme coordinates
        rows.insert(rows.size(), mk(3, XMIN, XMIN, 1, 0));
        rows.insert(rows.size(), mk(-1, XMAX, XMAX, 1, 0));
        rows.insert(rows.size(), mk(-1, 0, XMAX, 1, 0));
        rows.insert(rows.size(), mk(-1, -1, XMIN, 1, 0));
        rows.insert(rows.size(), mk(-1, 1, XMIN, 1, 0));
        rows.insert(rows.size(), mk(-1, XMAX - 1, 0, 1, 1));
        // four buckets, equal areas keep the first
        rows.insert(rows.size(), mk(4, 0, 0, 1, 0));
        rows.insert(rows.size(), mk(-1, 1, 1, 1, 0));
        rows.insert(rows.size(), mk(-1, 2, -1, 1, 0));
        rows.insert(rows.size(), mk(-1, 3, 1, 1, 0));
        rows.insert(rows.size(), mk(-1, 4, -1, 1, 0));
        rows.insert(rows.size(), mk(-1, 5, 0, 1, 0));
        rows.insert(rows.size(), mk(-1, 9, 9, 1, 1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].bc >= 0)
                set_buckets(rows[i].bc);
            send(rows[i].x, rows[i].y, rows[i].pv, rows[i].close);
            if (rows[i].typed)
            begin
                if (selected_q.size() == 0)
                begin
                    $display("%0t: row %0d: expected x=%0d y=%0d valid=%0b last=%0b, actual none",
                             $time, i, rows[i].res.x, rows[i].res.y, rows[i].res.valid,
                             rows[i].res.last);
                    errors++;
                end
                else if (!same_pt(selected_q[$], rows[i].res))
                begin
                    $display("%0t: row %0d: expected x=%0d y=%0d valid=%0b last=%0b",
                             $time, i, rows[i].res.x, rows[i].res.y, rows[i].res.valid,
                             rows[i].res.last);
                    $display("%0t: row %0d:   actual x=%0d y=%0d valid=%0b last=%0b",
                             $time, i, selected_q[$].x, selected_q[$].y,
                             selected_q[$].valid, selected_q[$].last);
                    errors++;
                end
            end
        end

        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0: begin s_idle = 0;  r_stall = 0;  end
                1: begin s_idle = 45; r_stall = 0;  end
                2: begin s_idle = 0;  r_stall = 45; end
                default: begin s_idle = 22; r_stall = 22; end
            endcase
            if (ph == 2)
            begin
                // long receiver hold-off while several sets keep coming
                hold_go = ~hold_go;
                rand_set(sent, 1'b1);
                for (int k = 0; k < 3; k++)
                    rand_set(sent, 1'b0);
            end
            while (sent < (ph + 1) * RAND_ITEMS / 4)
                rand_set(sent, 1'b1);
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && selected_q.size() == 0)
            $display("lttb_downsampler_tb: PASS");
        else
        begin
            if (selected_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, selected_q.size());
            $display("lttb_downsampler_tb: FAIL");
        end
        $finish;
    end

endmodule

[lttb_downsampler.f]
design/lttb_pkg.sv
design/lttb_store.sv
design/lttb_mul.sv
design/lttb_downsampler.sv
tb/sv/lttb_downsampler_tb.sv
